// ===== hdl/dcs_pkg.sv =====
// Shared types, codes and lookup tables for the DAQ command and capture sequencer.
// No dependencies; every other file in hdl imports this package.
package dcs_pkg;

	localparam logic [1:0] KIND_CMD_BYTE = 2'd0;
	localparam logic [1:0] KIND_END_MSG  = 2'd1;
	localparam logic [1:0] KIND_SAMPLE   = 2'd2;

	localparam logic [1:0] OUT_SETTING     = 2'd0;
	localparam logic [1:0] OUT_SAMPLE_KEPT = 2'd1;
	localparam logic [1:0] OUT_DONE_ONLY   = 2'd2;

	localparam logic [2:0] SET_RATE     = 3'd0;
	localparam logic [2:0] SET_GAIN     = 3'd1;
	localparam logic [2:0] SET_CHANNELS = 3'd2;
	localparam logic [2:0] SET_FILTER   = 3'd3;
	localparam logic [2:0] SET_DURATION = 3'd4;

	localparam logic [7:0] HEADER_BYTE = 8'hCA;
	localparam logic [7:0] OP_RATE     = 8'h61;
	localparam logic [7:0] OP_GAIN     = 8'h62;
	localparam logic [7:0] OP_CHANNEL  = 8'h63;
	localparam logic [7:0] OP_FILTER   = 8'h64;
	localparam logic [7:0] OP_DURATION = 8'h65;

	localparam logic [14:0] FAST_RATE_HZ  = 15'd20000;
	localparam logic [7:0]  SLOW_DIVIDER  = 8'h80;
	localparam logic [7:0]  FAST_DIVIDER  = 8'd2;
	localparam logic [15:0] FILT_PERIOD_DEFAULT  = 16'd41942;
	localparam logic [15:0] FILT_COMPARE_DEFAULT = 16'd20971;

	typedef enum logic [2:0] {
		PH_FIRST,
		PH_OPCODE,
		PH_ARG,
		PH_DUR_HI,
		PH_DUR_LO,
		PH_SKIP_ONE
	} parse_phase_t;

	typedef struct packed {
		logic [1:0]         out_kind;
		logic [2:0]         setting_id;
		logic [4:0]         gain_code;
		logic [3:0]         mux_lines;
		logic [3:0]         adc_power;
		logic [15:0]        filter_period;
		logic [15:0]        filter_compare;
		logic [14:0]        rate_hz;
		logic [7:0]         spi_divider;
		logic [6:0]         skip_ratio;
		logic signed [23:0] sample_value;
		logic               acquisition_done;
	} result_t;

	typedef struct packed {
		logic        load;
		logic [6:0]  skip_ratio;
		logic [30:0] target;
	} rate_load_t;

	function automatic logic [15:0] filt_period(input logic [3:0] mode);
		logic [15:0] v;
		unique case (mode)
			4'd0:    v = 16'd41942;
			4'd1:    v = 16'd20970;
			4'd2:    v = 16'd10484;
			4'd3:    v = 16'd5241;
			4'd4:    v = 16'd2620;
			4'd5:    v = 16'd1309;
			4'd6:    v = 16'd654;
			4'd7:    v = 16'd326;
			4'd8:    v = 16'd162;
			4'd9:    v = 16'd80;
			4'd10:   v = 16'd39;
			4'd11:   v = 16'd19;
			4'd12:   v = 16'd9;
			4'd13:   v = 16'd4;
			4'd14:   v = 16'd23;
			default: v = FILT_PERIOD_DEFAULT;
		endcase
		return v;
	endfunction

	function automatic logic [15:0] filt_compare(input logic [3:0] mode);
		logic [15:0] v;
		unique case (mode)
			4'd0:    v = 16'd20971;
			4'd1:    v = 16'd10485;
			4'd2:    v = 16'd5242;
			4'd3:    v = 16'd2621;
			4'd4:    v = 16'd1310;
			4'd5:    v = 16'd655;
			4'd6:    v = 16'd327;
			4'd7:    v = 16'd163;
			4'd8:    v = 16'd81;
			4'd9:    v = 16'd40;
			4'd10:   v = 16'd20;
			4'd11:   v = 16'd10;
			4'd12:   v = 16'd5;
			4'd13:   v = 16'd2;
			4'd14:   v = 16'd12;
			default: v = FILT_COMPARE_DEFAULT;
		endcase
		return v;
	endfunction

endpackage

// ===== hdl/dcs_cmd_parser.sv =====
// Command message parser: header check, opcode/argument sequencing and setting decode.
// Depends on dcs_pkg; hands rate updates to dcs_decimator through rate_load_t.
module dcs_cmd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [1:0]          kind,
	input  logic [7:0]          byte_value,
	output logic                res_valid,
	output dcs_pkg::result_t    res,
	output dcs_pkg::rate_load_t rate_load
);
	import dcs_pkg::*;

	parse_phase_t phase_q, phase_d;
	logic         header_valid_q, header_valid_d;
	logic [7:0]   pending_op_q;
	logic [7:0]   dur_high_q;
	logic [15:0]  duration_q;
	logic [14:0]  rate_q;

	logic         cmd_byte;
	logic         end_msg;
	logic         rate_cmd;
	logic [14:0]  rate_new;
	logic [7:0]   div_new;
	logic [6:0]   skip_new;
	logic [2:0]   fast_shift;
	logic [30:0]  target_new;

	assign cmd_byte = take && (kind == KIND_CMD_BYTE);
	assign end_msg  = take && (kind == KIND_END_MSG);
	assign rate_cmd = cmd_byte && (phase_q == PH_ARG) && (pending_op_q == OP_RATE);

	assign fast_shift = 3'(byte_value[3:0] - 4'd7);

	always_comb begin
		rate_new = rate_q;
		div_new  = SLOW_DIVIDER;
		skip_new = '0;
		if (byte_value <= 8'd6) begin
			rate_new = 15'd2 << byte_value[2:0];
			skip_new = 7'd127 >> byte_value[2:0];
		end else if (byte_value <= 8'd13) begin
			rate_new = 15'd256 << fast_shift;
			div_new  = SLOW_DIVIDER >> fast_shift;
		end else if (byte_value == 8'd14) begin
			rate_new = FAST_RATE_HZ;
			div_new  = FAST_DIVIDER;
		end
	end

	assign target_new = 31'({15'd0, duration_q} * {16'd0, rate_new});

	always_comb begin
		phase_d        = phase_q;
		header_valid_d = header_valid_q;
		if (end_msg) begin
			phase_d        = PH_FIRST;
			header_valid_d = 1'b0;
		end else if (cmd_byte) begin
			unique case (phase_q)
				PH_FIRST: begin
					header_valid_d = (byte_value == HEADER_BYTE);
					phase_d        = PH_OPCODE;
				end
				PH_OPCODE: begin
					if (header_valid_q) begin
						if (byte_value >= OP_RATE && byte_value <= OP_FILTER) begin
							phase_d = PH_ARG;
						end else if (byte_value == OP_DURATION) begin
							phase_d = PH_DUR_HI;
						end else begin
							phase_d = PH_SKIP_ONE;
						end
					end
				end
				PH_DUR_HI: phase_d = PH_DUR_LO;
				default:   phase_d = PH_OPCODE;
			endcase
		end
	end

	always_comb begin
		res       = '0;
		res_valid = 1'b0;
		res.out_kind = OUT_SETTING;
		if (cmd_byte && phase_q == PH_ARG) begin
			res_valid = 1'b1;
			unique case (pending_op_q)
				OP_RATE: begin
					res.setting_id  = SET_RATE;
					res.rate_hz     = rate_new;
					res.spi_divider = div_new;
					res.skip_ratio  = skip_new;
				end
				OP_GAIN: begin
					res.setting_id = SET_GAIN;
					res.gain_code  = (byte_value <= 8'd9) ? {byte_value[3:0], 1'b1} : 5'd1;
				end
				OP_CHANNEL: begin
					res.setting_id = SET_CHANNELS;
					res.mux_lines  = byte_value[3:0];
					res.adc_power  = byte_value[7:4];
				end
				default: begin
					res.setting_id     = SET_FILTER;
					res.filter_period  = (byte_value <= 8'd14) ?
						filt_period(byte_value[3:0]) : FILT_PERIOD_DEFAULT;
					res.filter_compare = (byte_value <= 8'd14) ?
						filt_compare(byte_value[3:0]) : FILT_COMPARE_DEFAULT;
				end
			endcase
		end else if (cmd_byte && phase_q == PH_DUR_LO) begin
			res_valid      = 1'b1;
			res.setting_id = SET_DURATION;
		end
	end

	assign rate_load.load       = rate_cmd;
	assign rate_load.skip_ratio = skip_new;
	assign rate_load.target     = target_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_FIRST;
			header_valid_q <= 1'b0;
			pending_op_q   <= '0;
			dur_high_q     <= '0;
			duration_q     <= '0;
			rate_q         <= '0;
		end else begin
			phase_q        <= phase_d;
			header_valid_q <= header_valid_d;
			if (cmd_byte && phase_q == PH_OPCODE && header_valid_q) begin
				pending_op_q <= byte_value;
			end
			if (cmd_byte && phase_q == PH_DUR_HI) begin
				dur_high_q <= byte_value;
			end
			if (cmd_byte && phase_q == PH_DUR_LO) begin
				duration_q <= {dur_high_q, byte_value};
			end
			if (rate_cmd) begin
				rate_q <= rate_new;
			end
		end
	end

endmodule

// ===== hdl/dcs_decimator.sv =====
// Sample frame decimator with kept-frame counting against the acquisition target.
// Depends on dcs_pkg; reloaded by rate commands from dcs_cmd_parser.
module dcs_decimator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [23:0]         raw_sample,
	input  dcs_pkg::rate_load_t rate_load,
	output logic                res_valid,
	output dcs_pkg::result_t    res
);
	import dcs_pkg::*;

	logic [6:0]  skip_ratio_q;
	logic [6:0]  skip_cnt_q, skip_cnt_d;
	logic [30:0] kept_q, kept_inc, kept_d;
	logic [30:0] target_q;
	logic        keep;
	logic        done;

	assign keep = (skip_cnt_q == '0);

	always_comb begin
		kept_inc = kept_q;
		if (keep) begin
			skip_cnt_d = (skip_ratio_q != '0) ? 7'd1 : 7'd0;
			kept_inc   = kept_q + 31'd1;
		end else if (skip_cnt_q == skip_ratio_q) begin
			skip_cnt_d = '0;
		end else begin
			skip_cnt_d = skip_cnt_q + 7'd1;
		end
	end

	assign done   = (kept_inc >= target_q);
	assign kept_d = done ? '0 : kept_inc;

	always_comb begin
		res = '0;
		res.sample_value     = raw_sample;
		res.acquisition_done = done;
		res.out_kind         = keep ? OUT_SAMPLE_KEPT : OUT_DONE_ONLY;
		if (!keep) begin
			res.sample_value = '0;
		end
		res_valid = take && (keep || done);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_ratio_q <= '0;
			skip_cnt_q   <= '0;
			kept_q       <= '0;
			target_q     <= '0;
		end else if (rate_load.load) begin
			skip_ratio_q <= rate_load.skip_ratio;
			skip_cnt_q   <= '0;
			kept_q       <= '0;
			target_q     <= rate_load.target;
		end else if (take) begin
			skip_cnt_q <= skip_cnt_d;
			kept_q     <= kept_d;
		end
	end

endmodule

// ===== hdl/dcs_out_fifo.sv =====
// Two-entry result queue between the decode logic and the output channel.
// Depends on dcs_pkg for the result_t payload.
module dcs_out_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dcs_pkg::result_t push_data,
	output logic             has_room,
	output logic             pop_valid,
	input  logic             pop_ready,
	output dcs_pkg::result_t pop_data
);
	import dcs_pkg::*;

	result_t    mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign has_room  = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop       = pop_valid && pop_ready;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/daq_command_and_capture_sequencer.sv =====
// Top level of the DAQ command and capture sequencer: parser, decimator, result queue.
// Depends on dcs_pkg, dcs_cmd_parser, dcs_decimator and dcs_out_fifo.
//
//   Channel  Handshake            Payload
//   input    in_valid/in_ready    kind, byte_value, raw_sample
//   output   out_valid/out_ready  out_kind ... acquisition_done (twelve fields)
//
// One item is accepted per cycle while in_ready is high; its result, if any, is registered in the result queue.
// The decode of an item and the state update it causes complete in the cycle in which it is accepted.
// A two-entry result queue lets one more item be taken while a result is stalled;
// in_ready drops only when both entries are full.
// Reset puts the parser in wait for a message header and clears all counters.
module daq_command_and_capture_sequencer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic [7:0]         byte_value,
	input  logic [23:0]        raw_sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         out_kind,
	output logic [2:0]         setting_id,
	output logic [4:0]         gain_code,
	output logic [3:0]         mux_lines,
	output logic [3:0]         adc_power,
	output logic [15:0]        filter_period,
	output logic [15:0]        filter_compare,
	output logic [14:0]        rate_hz,
	output logic [7:0]         spi_divider,
	output logic [6:0]         skip_ratio,
	output logic signed [23:0] sample_value,
	output logic               acquisition_done
);
	import dcs_pkg::*;

	logic       take;
	logic       sample_take;
	logic       cmd_valid;
	logic       dec_valid;
	result_t    cmd_res;
	result_t    dec_res;
	result_t    push_res;
	result_t    head;
	rate_load_t rate_load;

	assign take        = in_valid && in_ready;
	assign sample_take = take && (kind == KIND_SAMPLE);

	dcs_cmd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.kind       (kind),
		.byte_value (byte_value),
		.res_valid  (cmd_valid),
		.res        (cmd_res),
		.rate_load  (rate_load)
	);

	dcs_decimator u_decimator (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (sample_take),
		.raw_sample (raw_sample),
		.rate_load  (rate_load),
		.res_valid  (dec_valid),
		.res        (dec_res)
	);

	assign push_res = cmd_valid ? cmd_res : dec_res;

	dcs_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_valid || dec_valid),
		.push_data (push_res),
		.has_room  (in_ready),
		.pop_valid (out_valid),
		.pop_ready (out_ready),
		.pop_data  (head)
	);

	assign out_kind         = head.out_kind;
	assign setting_id       = head.setting_id;
	assign gain_code        = head.gain_code;
	assign mux_lines        = head.mux_lines;
	assign adc_power        = head.adc_power;
	assign filter_period    = head.filter_period;
	assign filter_compare   = head.filter_compare;
	assign rate_hz          = head.rate_hz;
	assign spi_divider      = head.spi_divider;
	assign skip_ratio       = head.skip_ratio;
	assign sample_value     = head.sample_value;
	assign acquisition_done = head.acquisition_done;

endmodule
